// ===== hdl/vector_projection_unit_assert.svh =====
// Assertion macros for the checker file of the projection unit.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef VECTOR_PROJECTION_UNIT_ASSERT_SVH
`define VECTOR_PROJECTION_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VPU_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vector_projection_unit check failed");

// Check a property on every clock edge, reset included.
`define VPU_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("vector_projection_unit check failed");

`endif

// ===== hdl/vpu_pkg.sv =====
// Shared constants of the vector projection unit.
// No dependencies.
`default_nettype none
package vpu_pkg;
   // default component width, signed Q8.8
   localparam int VPU_COMP_BITS_DEF = 16;
   // register stages ahead of the divider lanes
   localparam int VPU_FRONT_STAGES = 5;
endpackage
`default_nettype wire

// ===== hdl/vector_projection_unit.sv =====
// Top level of the 3-D vector projection unit: pipeline control, divider
// lanes and saturating output stage. Depends on vpu_pkg, vpu_front, vpu_div_lane.
`default_nettype none
// Projects vector a onto vector b, b_i*(a.b)/(b.b) per axis in signed Q8.8,
// truncated toward zero and saturated; a zero a or b gives zeros with the
// invalid flag. One request enters per clock while the pipeline is not held,
// and results leave in order through five front stages (decode, products,
// dot product, split multiply, numerator), one stage per quotient bit in
// each of three restoring divider lanes, and the output register. Each
// stage holds only while full and blocked downstream, so empty stages fill
// in under back pressure.
module vector_projection_unit
   import vpu_pkg::*;
#(
   parameter int COMPONENT_BITS = VPU_COMP_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z from the lowest bit, zero padded
   input  wire logic [((6*COMPONENT_BITS+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // proj_x, proj_y, proj_z from the lowest bit, zero padded
   output logic      [((3*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata,
   // invalid
   output logic      [0:0] rsp_tuser
);
   localparam int W  = COMPONENT_BITS;
   localparam int F  = VPU_FRONT_STAGES;
   localparam int NS = F + W + 1;
   localparam int RW = ((3*W+7)/8)*8;

   logic [NS-1:0]  valid_ff;
   logic [NS-1:0]  en;
   logic [3*W+1:0] num [3];
   logic [2*W+1:0] den;
   logic [2:0]     rneg_f;
   logic           zero_f;
   logic [W-1:0]   quot [3];
   logic [2:0]     rneg_l;
   logic           zero_l;
   logic [W-1:0]   proj_in [3];
   logic [W-1:0]   proj_ff [3];
   logic           inv_ff;

   // advance a stage when it is empty or its successor advances
   always_comb begin
      en[NS-1] = !valid_ff[NS-1] || rsp_tready;
      for (int k = NS-2; k >= 0; k--)
         en[k] = !valid_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= req_tvalid;
         for (int k = 1; k < NS; k++)
            if (en[k]) valid_ff[k] <= valid_ff[k-1];
      end
   end

   assign req_tready = en[0];

   vpu_front #(.W(W)) u_front (
      .clock (clock),
      .en    (en[F-1:0]),
      .a_x   (req_tdata[W-1:0]),
      .a_y   (req_tdata[2*W-1:W]),
      .a_z   (req_tdata[3*W-1:2*W]),
      .b_x   (req_tdata[4*W-1:3*W]),
      .b_y   (req_tdata[5*W-1:4*W]),
      .b_z   (req_tdata[6*W-1:5*W]),
      .num_x (num[0]),
      .num_y (num[1]),
      .num_z (num[2]),
      .den   (den),
      .rneg  (rneg_f),
      .zero  (zero_f)
   );

   vpu_div_lane #(.W(W)) u_lane_x (
      .clock (clock), .en (en[F+W-1:F]), .num_in (num[0]), .den_in (den),
      .rneg_in (rneg_f[0]), .zero_in (zero_f),
      .quot (quot[0]), .rneg_out (rneg_l[0]), .zero_out (zero_l)
   );

   vpu_div_lane #(.W(W)) u_lane_y (
      .clock (clock), .en (en[F+W-1:F]), .num_in (num[1]), .den_in (den),
      .rneg_in (rneg_f[1]), .zero_in (zero_f),
      .quot (quot[1]), .rneg_out (rneg_l[1]), .zero_out ()
   );

   vpu_div_lane #(.W(W)) u_lane_z (
      .clock (clock), .en (en[F+W-1:F]), .num_in (num[2]), .den_in (den),
      .rneg_in (rneg_f[2]), .zero_in (zero_f),
      .quot (quot[2]), .rneg_out (rneg_l[2]), .zero_out ()
   );

   // saturate, apply sign, force zero for a zero vector
   always_comb begin
      logic [W-1:0] lim, sat;
      for (int i = 0; i < 3; i++) begin
         lim = rneg_l[i] ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
         sat = (quot[i] > lim) ? lim : quot[i];
         if (zero_l)         proj_in[i] = '0;
         else if (rneg_l[i]) proj_in[i] = ~sat + W'(1);
         else                proj_in[i] = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         proj_ff <= proj_in;
         inv_ff  <= zero_l;
      end
   end

   assign rsp_tvalid   = valid_ff[NS-1];
   assign rsp_tdata    = RW'({proj_ff[2], proj_ff[1], proj_ff[0]});
   assign rsp_tuser[0] = inv_ff;
endmodule
`default_nettype wire

// ===== hdl/vpu_front.sv =====
// Front end of the projection pipeline: decode, products, dot product and
// squared length, split numerator multiply. Depends on vpu_pkg.
`default_nettype none
module vpu_front
   import vpu_pkg::*;
#(
   parameter int W = VPU_COMP_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic [VPU_FRONT_STAGES-1:0] en,
   input  wire logic [W-1:0]             a_x,
   input  wire logic [W-1:0]             a_y,
   input  wire logic [W-1:0]             a_z,
   input  wire logic [W-1:0]             b_x,
   input  wire logic [W-1:0]             b_y,
   input  wire logic [W-1:0]             b_z,
   output logic      [3*W+1:0]           num_x,
   output logic      [3*W+1:0]           num_y,
   output logic      [3*W+1:0]           num_z,
   output logic      [2*W+1:0]           den,
   output logic      [2:0]               rneg,
   output logic                          zero
);
   localparam int S = 2*W + 2;
   localparam int H = W + 1;
   localparam int N = 3*W + 2;
   localparam int P = 2*W + 1;

   logic [W-1:0] a_raw [3];
   logic [W-1:0] b_raw [3];

   // stage 0: sign and magnitude
   logic [W-1:0] amag_ff [3];
   logic [W-1:0] bmag0_ff [3];
   logic [2:0]   aneg_ff, bneg0_ff;
   logic         zero0_ff;
   // stage 1: component products
   logic [2*W-1:0] ab_ff [3];
   logic [2*W-1:0] bb_ff [3];
   logic [W-1:0]   bmag1_ff [3];
   logic [2:0]     pneg_ff, bneg1_ff;
   logic           zero1_ff;
   // stage 2: dot product and squared length
   logic [S-1:0]   pos_in, negs_in;
   logic [S-1:0]   dmag_ff, den2_ff;
   logic [W-1:0]   bmag2_ff [3];
   logic [2:0]     rneg2_ff;
   logic           zero2_ff;
   // stage 3: split products
   logic [P-1:0]   plo_ff [3];
   logic [P-1:0]   phi_ff [3];
   logic [S-1:0]   den3_ff;
   logic [2:0]     rneg3_ff;
   logic           zero3_ff;
   // stage 4: numerator
   logic [N-1:0]   num_ff [3];
   logic [S-1:0]   den4_ff;
   logic [2:0]     rneg4_ff;
   logic           zero4_ff;

   assign a_raw[0] = a_x;
   assign a_raw[1] = a_y;
   assign a_raw[2] = a_z;
   assign b_raw[0] = b_x;
   assign b_raw[1] = b_y;
   assign b_raw[2] = b_z;

   // decode signs and magnitudes, flag zero vectors
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            aneg_ff[i]  <= a_raw[i][W-1];
            bneg0_ff[i] <= b_raw[i][W-1];
            amag_ff[i]  <= a_raw[i][W-1] ? (~a_raw[i] + W'(1)) : a_raw[i];
            bmag0_ff[i] <= b_raw[i][W-1] ? (~b_raw[i] + W'(1)) : b_raw[i];
         end
         zero0_ff <= ((a_x | a_y | a_z) == '0) || ((b_x | b_y | b_z) == '0);
      end
   end

   // form the six magnitude products
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i]    <= (2*W)'(amag_ff[i]) * (2*W)'(bmag0_ff[i]);
            bb_ff[i]    <= (2*W)'(bmag0_ff[i]) * (2*W)'(bmag0_ff[i]);
            pneg_ff[i]  <= aneg_ff[i] ^ bneg0_ff[i];
            bmag1_ff[i] <= bmag0_ff[i];
         end
         bneg1_ff <= bneg0_ff;
         zero1_ff <= zero0_ff;
      end
   end

   // sum positive and negative terms separately
   always_comb begin
      pos_in  = '0;
      negs_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (pneg_ff[i]) negs_in = negs_in + S'(ab_ff[i]);
         else            pos_in  = pos_in + S'(ab_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         if (pos_in >= negs_in) begin
            dmag_ff  <= pos_in - negs_in;
            rneg2_ff <= bneg1_ff;
         end else begin
            dmag_ff  <= negs_in - pos_in;
            rneg2_ff <= ~bneg1_ff;
         end
         den2_ff  <= S'(bb_ff[0]) + S'(bb_ff[1]) + S'(bb_ff[2]);
         bmag2_ff <= bmag1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // multiply b magnitude by the dot product in two halves
   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            plo_ff[i] <= P'(bmag2_ff[i]) * P'(dmag_ff[H-1:0]);
            phi_ff[i] <= P'(bmag2_ff[i]) * P'(dmag_ff[S-1:H]);
         end
         den3_ff  <= den2_ff;
         rneg3_ff <= rneg2_ff;
         zero3_ff <= zero2_ff;
      end
   end

   // join the halves
   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++)
            num_ff[i] <= N'(plo_ff[i]) + (N'(phi_ff[i]) << H);
         den4_ff  <= den3_ff;
         rneg4_ff <= rneg3_ff;
         zero4_ff <= zero3_ff;
      end
   end

   assign num_x = num_ff[0];
   assign num_y = num_ff[1];
   assign num_z = num_ff[2];
   assign den   = den4_ff;
   assign rneg  = rneg4_ff;
   assign zero  = zero4_ff;
endmodule
`default_nettype wire

// ===== hdl/vpu_div_lane.sv =====
// One restoring divider lane, one quotient bit per register stage.
// Depends on vpu_pkg.
`default_nettype none
module vpu_div_lane
   import vpu_pkg::*;
#(
   parameter int W = VPU_COMP_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic [W-1:0]     en,
   input  wire logic [3*W+1:0]   num_in,
   input  wire logic [2*W+1:0]   den_in,
   input  wire logic             rneg_in,
   input  wire logic             zero_in,
   output logic      [W-1:0]     quot,
   output logic                  rneg_out,
   output logic                  zero_out
);
   localparam int S = 2*W + 2;
   localparam int Q = W;

   logic [S-1:0] r_ff [Q];
   logic [Q-1:0] n_ff [Q];
   logic [Q-1:0] q_ff [Q];
   logic [S-1:0] d_ff [Q];
   logic [Q-1:0] rneg_ff, zero_ff;

   genvar s;
   generate
      for (s = 0; s < Q; s++) begin : g_stage
         logic [S-1:0] r_prev, d_prev;
         logic [Q-1:0] n_prev, q_prev;
         logic         rneg_prev, zero_prev;
         logic [S:0]   t_w, diff_w;
         logic         ge_w;

         if (s == 0) begin : g_first
            // quotient is known to fit Q bits, so the top part is below d
            assign r_prev    = num_in[3*W+1:Q];
            assign n_prev    = num_in[Q-1:0];
            assign q_prev    = '0;
            assign d_prev    = den_in;
            assign rneg_prev = rneg_in;
            assign zero_prev = zero_in;
         end else begin : g_next
            assign r_prev    = r_ff[s-1];
            assign n_prev    = n_ff[s-1];
            assign q_prev    = q_ff[s-1];
            assign d_prev    = d_ff[s-1];
            assign rneg_prev = rneg_ff[s-1];
            assign zero_prev = zero_ff[s-1];
         end

         // shift in one numerator bit, subtract if it fits
         assign t_w    = {r_prev, n_prev[Q-1]};
         assign ge_w   = t_w >= {1'b0, d_prev};
         assign diff_w = t_w - {1'b0, d_prev};

         always_ff @(posedge clock) begin
            if (en[s]) begin
               r_ff[s]    <= ge_w ? diff_w[S-1:0] : t_w[S-1:0];
               n_ff[s]    <= n_prev << 1;
               q_ff[s]    <= {q_prev[Q-2:0], ge_w};
               d_ff[s]    <= d_prev;
               rneg_ff[s] <= rneg_prev;
               zero_ff[s] <= zero_prev;
            end
         end
      end
   endgenerate

   assign quot     = q_ff[Q-1];
   assign rneg_out = rneg_ff[Q-1];
   assign zero_out = zero_ff[Q-1];
endmodule
`default_nettype wire

// ===== hdl/vpu_checker.sv =====
// Port-level checker for the vector projection unit, bound to the top level.
// Depends on vector_projection_unit_assert.svh.
`default_nettype none
`include "vector_projection_unit_assert.svh"
module vpu_checker #(
   parameter int RW = 48
) (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [RW-1:0] rsp_tdata,
   input wire logic [0:0]    rsp_tuser
);
   // an invalid response carries an all-zero projection
   `VPU_ASSERT(inv_zero_proj, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
   // no response right after reset
   `VPU_ASSERT_ALWAYS(no_rsp_after_reset, $past(reset) |-> !rsp_tvalid)
   // a blocked response stays offered
   `VPU_ASSERT(rsp_hold_valid, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
   // a blocked response keeps its payload
   `VPU_ASSERT(rsp_hold_data,
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
endmodule

bind vector_projection_unit vpu_checker #(.RW(((3*COMPONENT_BITS+7)/8)*8)) u_vpu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
